@@ rtl/pms_pkg.sv @@
`timescale 1ns / 1ps
// Package for the presample mean and sigma core: widths, limits, the
// snapshot struct that the front hands to the back, and the back's states.
// Depends on nothing.
package pms_pkg;

    localparam int MAX_PRESAMPLES = 1024;
    localparam int SAMPLE_W = 24;
    localparam int CNT_W = 11;
    localparam int SUM_W = 35;
    localparam int SQ_W = 57;
    localparam int MAG_W = 34;
    localparam int PROD_W = 68;
    localparam int DVD_W = 84;
    localparam int DVS_W = 20;
    localparam int ROOT_W = 64;
    localparam int OUT_W = 32;
    localparam int FRAC_BITS = 8;
    localparam int SIG_SHIFT = 16;
    localparam int Q_DEPTH = 2;
    localparam int STEP_W = 7;
    localparam int MUL_STEPS = MAG_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int SQRT_STEPS = ROOT_W / 2;
    localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(16);

    typedef struct packed {
        logic                    accepted;
        logic [CNT_W-1:0]        count;
        logic                    full;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } t_snap;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_DIV_SIG,
        S_SQRT,
        S_DIV_MEAN,
        S_DONE
    } t_state;

endpackage

@@ rtl/pms_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the presample mean and sigma core: input items,
// result items and the configuration write channel. Depends on pms_pkg.
interface pms_in_if;
    import pms_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       start_new;
    logic signed [SAMPLE_W-1:0] sample_value;
    modport source(output valid, start_new, sample_value, input ready);
    modport sink(input valid, start_new, sample_value, output ready);
endinterface

interface pms_out_if;
    import pms_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [CNT_W-1:0]         sample_count;
    logic                     is_full;
    logic signed [OUT_W-1:0]  mean_value;
    logic [OUT_W-1:0]         sigma_value;
    modport source(output valid, accepted, sample_count, is_full, mean_value,
                   sigma_value, input ready);
    modport sink(input valid, accepted, sample_count, is_full, mean_value,
                 sigma_value, output ready);
endinterface

interface pms_cfg_if;
    import pms_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

@@ rtl/pms_front.sv @@
`timescale 1ns / 1ps
// Front part: holds the target register, takes input items and updates the
// count, sum and sum of squares. Depends on pms_pkg and pms_if.
module pms_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pms_in_if.sink        i_in,
    pms_cfg_if.sink       i_cfg,
    input  logic          i_q_ready,
    output logic          o_push,
    output pms_pkg::t_snap o_snap
);
    import pms_pkg::*;

    logic [CNT_W-1:0]        r_target;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;

    logic [CNT_W-1:0]        w_target;
    logic [CNT_W-1:0]        w_cnt0;
    logic signed [SUM_W-1:0] w_sum0;
    logic [SQ_W-1:0]         w_sq0;
    logic                    w_take;
    logic signed [2*SAMPLE_W-1:0] w_sqr;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [SUM_W-1:0] n_sum;
    logic [SQ_W-1:0]         n_sq;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign o_push      = i_in.valid & i_q_ready;

    assign w_target = (r_target > CNT_W'(MAX_PRESAMPLES)) ? CNT_W'(MAX_PRESAMPLES) : r_target;
    assign w_cnt0   = i_in.start_new ? '0 : r_cnt;
    assign w_sum0   = i_in.start_new ? '0 : r_sum;
    assign w_sq0    = i_in.start_new ? '0 : r_sq;
    assign w_take   = w_cnt0 < w_target;
    assign w_sqr    = i_in.sample_value * i_in.sample_value;

    always_comb begin
        n_cnt = w_cnt0;
        n_sum = w_sum0;
        n_sq  = w_sq0;
        if (w_take) begin
            n_cnt = w_cnt0 + CNT_W'(1);
            n_sum = w_sum0 + SUM_W'(i_in.sample_value);
            n_sq  = w_sq0 + SQ_W'($unsigned(w_sqr));
        end
    end

    always_comb begin
        o_snap.accepted = w_take;
        o_snap.count    = n_cnt;
        o_snap.full     = n_cnt >= w_target;
        o_snap.sum      = n_sum;
        o_snap.sq       = n_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_target <= i_cfg.data;
            end
            if (o_push) begin
                r_cnt <= n_cnt;
                r_sum <= n_sum;
                r_sq  <= n_sq;
            end
        end
    end

endmodule

@@ rtl/pms_queue.sv @@
`timescale 1ns / 1ps
// Short queue of accumulator snapshots between the front and the back.
// Depends on pms_pkg.
module pms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pms_pkg::t_snap i_snap,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output pms_pkg::t_snap o_snap
);
    import pms_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_snap              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_fill;

    assign o_ready = r_fill != (PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_snap  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_fill <= r_fill + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

@@ rtl/pms_back.sv @@
`timescale 1ns / 1ps
// Back part: serial multiplier, restoring divider and integer square root
// that turn one snapshot into mean and sigma. Depends on pms_pkg and pms_if.
module pms_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pms_pkg::t_snap i_snap,
    output logic           o_pop,
    pms_out_if.source      o_out
);
    import pms_pkg::*;

    t_state               r_state, n_state;
    t_snap                r_snap, n_snap;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [PROD_W-1:0]    r_mcand, n_mcand, r_prod, n_prod, r_a, n_a;
    logic [MAG_W-1:0]     r_mplier, n_mplier;
    logic [DVD_W-1:0]     r_dvd, n_dvd;
    logic [DVS_W-1:0]     r_rem, n_rem, r_dvs, n_dvs;
    logic [ROOT_W-1:0]    r_x, n_x, r_res, n_res, r_bit, n_bit;
    logic                 r_sat, n_sat;
    logic [OUT_W-1:0]     r_sigma, n_sigma, r_mean, n_mean;

    logic                 r_ov;
    logic                 r_o_acc;
    logic [CNT_W-1:0]     r_o_cnt;
    logic                 r_o_full;
    logic [OUT_W-1:0]     r_o_mean, r_o_sigma;

    logic                 w_neg;
    logic [MAG_W-1:0]     w_mag;
    logic [PROD_W-1:0]    w_prod;
    logic [DVS_W:0]       w_t;
    logic                 w_ge;
    logic [DVD_W-1:0]     w_q;
    logic [ROOT_W-1:0]    w_rb, w_res;
    logic                 w_last;
    logic                 w_load;

    assign w_neg  = r_snap.sum < 0;
    assign w_mag  = w_neg ? MAG_W'(-r_snap.sum) : MAG_W'(r_snap.sum);
    assign w_prod = r_mplier[0] ? r_prod + r_mcand : r_prod;
    assign w_t    = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge   = w_t >= {1'b0, r_dvs};
    assign w_q    = {r_dvd[DVD_W-2:0], w_ge};
    assign w_rb   = r_res + r_bit;
    assign w_res  = (r_x >= w_rb) ? (r_res >> 1) + r_bit : r_res >> 1;
    assign w_load = (r_state == S_DONE) && (!r_ov || o_out.ready);
    assign o_pop  = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        unique case (r_state)
            S_MUL_A, S_MUL_B: w_last = r_step == STEP_W'(MUL_STEPS - 1);
            S_DIV_SIG, S_DIV_MEAN: w_last = r_step == STEP_W'(DIV_STEPS - 1);
            S_SQRT: w_last = r_step == STEP_W'(SQRT_STEPS - 1);
            default: w_last = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_MUL_A;
            S_MUL_A: if (w_last) n_state = S_MUL_B;
            S_MUL_B: if (w_last) n_state = S_DIV_SIG;
            S_DIV_SIG: if (w_last) n_state = S_SQRT;
            S_SQRT: if (w_last) n_state = S_DIV_MEAN;
            S_DIV_MEAN: if (w_last) n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates for each state.
    always_comb begin
        n_snap   = r_snap;
        n_step   = r_step + STEP_W'(1);
        n_mcand  = r_mcand << 1;
        n_mplier = r_mplier >> 1;
        n_prod   = w_prod;
        n_a      = r_a;
        n_dvd    = w_q;
        n_rem    = w_ge ? DVS_W'(w_t - {1'b0, r_dvs}) : w_t[DVS_W-1:0];
        n_dvs    = r_dvs;
        n_x      = (r_x >= w_rb) ? r_x - w_rb : r_x;
        n_res    = w_res;
        n_bit    = r_bit >> 2;
        n_sat    = r_sat;
        n_sigma  = r_sigma;
        n_mean   = r_mean;
        unique case (r_state)
            S_IDLE: begin
                n_snap   = i_snap;
                n_step   = '0;
                n_mcand  = PROD_W'(i_snap.sq);
                n_mplier = MAG_W'(i_snap.count);
                n_prod   = '0;
            end
            S_MUL_A: begin
                if (w_last) begin
                    n_a      = w_prod;
                    n_step   = '0;
                    n_mcand  = PROD_W'(w_mag);
                    n_mplier = w_mag;
                    n_prod   = '0;
                end
            end
            S_MUL_B: begin
                if (w_last) begin
                    n_step = '0;
                    n_dvd  = (r_a >= w_prod) ? {r_a - w_prod, SIG_SHIFT'(0)} : '0;
                    n_rem  = '0;
                    n_dvs  = DVS_W'(r_snap.count) * DVS_W'(r_snap.count - CNT_W'(1));
                end
            end
            S_DIV_SIG: begin
                if (w_last) begin
                    n_step = '0;
                    n_sat  = |w_q[DVD_W-1:ROOT_W];
                    n_x    = w_q[ROOT_W-1:0];
                    n_res  = '0;
                    n_bit  = ROOT_W'(1) << (ROOT_W - 2);
                end
            end
            S_SQRT: begin
                if (w_last) begin
                    n_step  = '0;
                    n_sigma = r_sat ? '1 : w_res[OUT_W-1:0];
                    n_dvd   = DVD_W'({w_mag, FRAC_BITS'(0)});
                    n_rem   = '0;
                    n_dvs   = DVS_W'(r_snap.count);
                end
            end
            S_DIV_MEAN: begin
                if (w_last) begin
                    n_mean = w_neg ? -w_q[OUT_W-1:0] : w_q[OUT_W-1:0];
                end
            end
            S_DONE: n_step = r_step;
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_snap   <= n_snap;
        r_step   <= n_step;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_a      <= n_a;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_x      <= n_x;
        r_res    <= n_res;
        r_bit    <= n_bit;
        r_sat    <= n_sat;
        r_sigma  <= n_sigma;
        r_mean   <= n_mean;
        if (w_load) begin
            r_o_acc   <= r_snap.accepted;
            r_o_cnt   <= r_snap.count;
            r_o_full  <= r_snap.full;
            r_o_mean  <= (r_snap.count == '0) ? '0 : r_mean;
            r_o_sigma <= (r_snap.count < CNT_W'(2)) ? '0 : r_sigma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.accepted     = r_o_acc;
    assign o_out.sample_count = r_o_cnt;
    assign o_out.is_full      = r_o_full;
    assign o_out.mean_value   = $signed(r_o_mean);
    assign o_out.sigma_value  = r_o_sigma;

`ifndef SYNTH
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_MUL_A)
        else $error("pop did not start the multiply");
    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_snap.count == '0 |=> o_out.mean_value == '0)
        else $error("mean not zero for an empty window");
    a_short_sigma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_snap.count < CNT_W'(2) |=> o_out.sigma_value == '0)
        else $error("sigma not zero below two samples");
`endif

endmodule

@@ rtl/presample_mean_sigma_core.sv @@
`timescale 1ns / 1ps
// Top level of the presample mean and sigma core: front, snapshot queue and
// back. Depends on pms_pkg, pms_if, pms_front, pms_queue and pms_back.
//
//   Channel   Direction  Payload
//   i_in      sink       start_new, sample_value
//   o_out     source     accepted, sample_count, is_full, mean_value, sigma_value
//   i_cfg     sink       data (target_count), always ready
//
// The front takes one item per cycle while the two-entry queue has room and
// folds it into the count, sum and sum of squares in that same cycle.
// The back works on one snapshot at a time: it takes the snapshot, forms two products on the
// shared serial multiplier, runs the restoring divider for the variance, the square root and
// the divider again for the mean, and then loads the output register.
// The output register holds a finished item while the back starts the next.
// Reset is synchronous and active low; it clears the sums and sets the target
// to 16.
module presample_mean_sigma_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pms_in_if.sink    i_in,
    pms_cfg_if.sink   i_cfg,
    pms_out_if.source o_out
);
    import pms_pkg::*;

    logic  w_push, w_q_ready, w_q_valid, w_pop;
    t_snap w_snap_in, w_snap_out;

    // The front classifies each item as accepted or rejected and snapshots
    // the window state after it.
    pms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_snap    (w_snap_in)
    );

    pms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_snap  (w_snap_in),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_snap  (w_snap_out)
    );

    // The back computes the mean and the sample sigma of each snapshot.
    pms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_snap    (w_snap_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

@@ dv/tb_presample_mean_sigma_core.sv @@
`timescale 1ns / 1ps
// Testbench for the presample mean and sigma core: directed and random items
// checked against an integer model of count, mean and sigma.
// Depends on pms_pkg, pms_if and presample_mean_sigma_core.

class pms_scoreboard;
    typedef struct {
        logic                    accepted;
        logic [pms_pkg::CNT_W-1:0] count;
        logic                    full;
        logic [31:0]             mean;
        logic [31:0]             sigma;
    } t_result;

    int unsigned target = 16;
    int unsigned n_stored;
    longint      sum;
    logic [63:0] sq_sum;
    t_result     pending[$];
    int          errors;
    int          checked;

    function void clear_window();
        n_stored = 0;
        sum = 0;
        sq_sum = 0;
    endfunction

    function void set_target(logic [10:0] value);
        target = value;
    endfunction

    // Integer square root by bitwise search.
    function logic [63:0] int_sqrt(logic [127:0] x);
        logic [63:0] r;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x) r = t;
        end
        return r;
    endfunction

    function void note_item(logic start_new, logic signed [23:0] value);
        t_result     res;
        int unsigned eff;
        logic [127:0] var_num;
        logic [127:0] q;
        logic [63:0]  mag;
        logic [63:0]  root;
        eff = (target > pms_pkg::MAX_PRESAMPLES) ? pms_pkg::MAX_PRESAMPLES : target;
        if (start_new) clear_window();
        res.accepted = 0;
        if (n_stored < eff) begin
            n_stored++;
            sum += longint'(value);
            sq_sum += 64'(longint'(value) * longint'(value));
            res.accepted = 1;
        end
        res.count = n_stored[10:0];
        res.full = (n_stored >= eff);
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        res.mean = 0;
        if (n_stored != 0) begin
            q = ({64'd0, mag} << 8) / n_stored;
            res.mean = (sum < 0) ? 32'(-q) : 32'(q);
        end
        res.sigma = 0;
        if (n_stored >= 2) begin
            var_num = 128'(n_stored) * {64'd0, sq_sum} - {64'd0, mag} * {64'd0, mag};
            if (128'(n_stored) * {64'd0, sq_sum} >= {64'd0, mag} * {64'd0, mag}) begin
                q = (var_num << 16) / (128'(n_stored) * 128'(n_stored - 1));
                if (q[127:64] != 0) begin
                    res.sigma = 32'hFFFF_FFFF;
                end else begin
                    root = int_sqrt(q);
                    res.sigma = root[31:0];
                end
            end
        end
        pending = {pending, res};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    task check_result(logic accepted, logic [10:0] count, logic full,
                      logic [31:0] mean, logic [31:0] sigma);
        t_result w;
        if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        w = pending.pop_front();
        checked++;
        if (accepted !== w.accepted) report("accepted", accepted, w.accepted);
        if (count !== w.count) report("sample_count", count, w.count);
        if (full !== w.full) report("is_full", full, w.full);
        if (mean !== w.mean) report("mean_value", mean, w.mean);
        if (sigma !== w.sigma) report("sigma_value", sigma, w.sigma);
    endtask
endclass

module tb_presample_mean_sigma_core;
    import pms_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    longint cycles = 0;
    int     sent = 0;
    int     big_stalls = 1;
    bit     sink_done = 0;

    pms_in_if  in_ch();
    pms_out_if out_ch();
    pms_cfg_if cfg_ch();

    presample_mean_sigma_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    pms_scoreboard board = new();

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // A watchdog ends the run as a mismatch once the cycle count passes its limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd5000 * 700) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 0;
        in_ch.start_new = 0;
        in_ch.sample_value = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        out_ch.ready = 0;
    end

    // The result side stalls at random before each item,
    // except in stretches where stalls are turned off.
    initial begin
        int gap;
        @(negedge i_clk);
        while (!sink_done) begin
            gap = big_stalls ? $urandom_range(0, 16) : 0;
            repeat (gap) @(negedge i_clk);
            out_ch.ready = 1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            board.check_result(out_ch.accepted, out_ch.sample_count, out_ch.is_full,
                               out_ch.mean_value, out_ch.sigma_value);
            @(negedge i_clk);
            out_ch.ready = 0;
        end
    end

    task send_item(logic start_new, logic signed [23:0] value);
        int gap;
        gap = big_stalls ? $urandom_range(0, 16) : 0;
        repeat (gap) @(negedge i_clk);
        in_ch.valid = 1;
        in_ch.start_new = start_new;
        in_ch.sample_value = value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(start_new, value);
        sent++;
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    // Every item yields a result, so once the queue is empty the core is idle.
    task drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task write_target(logic [10:0] value);
        cfg_ch.valid = 1;
        cfg_ch.data = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.set_target(value);
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    function logic signed [23:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 24'sh7FFFFF - 24'($urandom_range(0, 3));
            1: return 24'sh800000 + 24'($urandom_range(0, 3));
            2: return 24'($urandom_range(0, 200)) - 24'sd100;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int tgt;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: reset target of 16, extremes, overflowing the window.
        send_item(1, 24'sh7FFFFF);
        send_item(0, 24'sh800000);
        send_item(0, 24'sh7FFFFF);
        send_item(0, 0);
        send_item(1, 24'sh800000);
        send_item(0, 24'sh800000);
        send_item(1, -24'sd1);
        for (int k = 0; k < 16; k++) send_item(0, 24'sh7FFFFF);
        drain();
        // A zero target rejects everything; a target above capacity saturates;
        // lowering the target below the count keeps the stored samples.
        write_target(0);
        send_item(0, 24'sd5);
        send_item(1, -24'sd5);
        drain();
        write_target(11'h7FF);
        send_item(1, 24'sd3);
        send_item(0, 24'sd4);
        send_item(0, -24'sd9);
        drain();
        write_target(1);
        send_item(0, 24'sd7);
        send_item(1, 24'sd7);
        drain();

        // Random windows of random size; some phases run without stalls.
        for (int ph = 0; ph < 10; ph++) begin
            big_stalls = (ph % 3 != 2);
            case (ph)
                0: tgt = 2;
                4: tgt = 1024;
                7: tgt = 1025 + $urandom_range(0, 1022);
                default: tgt = $urandom_range(0, 40);
            endcase
            write_target(11'(tgt));
            for (int k = 0; k < 27; k++)
                send_item($urandom_range(0, 9) == 0, rand_sample());
            drain();
        end

        // A long window of alternating extremes, large sums of squares.
        big_stalls = 0;
        write_target(11'd1024);
        send_item(1, 24'sh800000);
        for (int k = 0; k < 200; k++) send_item(0, k[0] ? 24'sh7FFFFF : 24'sh800000);
        drain();
        sink_done = 1;

        $display("Ran %0d items across windows with targets from 0 to above capacity;",
                 sent);
        $display("%0d results were compared field by field.", board.checked);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/pms_pkg.sv
rtl/pms_if.sv
rtl/pms_front.sv
rtl/pms_queue.sv
rtl/pms_back.sv
rtl/presample_mean_sigma_core.sv
dv/tb_presample_mean_sigma_core.sv
